// ===== rtl/ksb_pkg.sv =====
// Shared types, constants and helper functions for the Kronecker symbol block.
`timescale 1ns / 1ps
`default_nettype none
package ksb_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int FIELD_W       = 64;
    localparam int S_DATA_W      = 2 * FIELD_W;
    localparam int SYM_W         = 2;
    localparam int M_DATA_W      = 8;

    typedef logic signed [SYM_W-1:0] sym_t;

    localparam sym_t SYM_ZERO = 2'sb00;
    localparam sym_t SYM_POS  = 2'sb01;
    localparam sym_t SYM_NEG  = 2'sb11;

    typedef struct packed {
        logic load;
        logic set_early;
        logic strip_b;
        logic div_init;
        logic div_step;
        logic fix;
        logic loop_step;
        logic set_final;
        logic emit;
    } ksb_cmd_t;

    typedef struct packed {
        logic b_zero;
        logic both_even;
        logic b_odd;
        logic div_last;
        logic a_zero;
        logic out_free;
    } ksb_sts_t;

    function automatic sym_t sign_mod8(input logic [2:0] r);
        sym_t s;
        case (r)
            3'd1, 3'd7: s = SYM_POS;
            3'd3, 3'd5: s = SYM_NEG;
            default:    s = SYM_ZERO;
        endcase
        return s;
    endfunction

    function automatic sym_t sym_mul(input sym_t x, input sym_t y);
        sym_t s;
        if (x == SYM_ZERO || y == SYM_ZERO) begin
            s = SYM_ZERO;
        end else if (x == y) begin
            s = SYM_POS;
        end else begin
            s = SYM_NEG;
        end
        return s;
    endfunction

    function automatic sym_t sym_neg(input sym_t x);
        sym_t s;
        if (x == SYM_POS) begin
            s = SYM_NEG;
        end else if (x == SYM_NEG) begin
            s = SYM_POS;
        end else begin
            s = SYM_ZERO;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ksb_ctrl.sv =====
// Controller state machine sequencing the Kronecker symbol datapath.
`timescale 1ns / 1ps
`default_nettype none
module ksb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire ksb_pkg::ksb_sts_t sts,
    output ksb_pkg::ksb_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_STRIP = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;
    localparam logic [2:0] ST_LOOP  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.b_zero || sts.both_even) begin
                    cmd.set_early = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (sts.b_odd) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end else begin
                    cmd.strip_b = 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_LOOP;
            end
            ST_LOOP: begin
                if (sts.a_zero) begin
                    cmd.set_final = 1'b1;
                    state_next    = ST_OUT;
                end else begin
                    cmd.loop_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ksb_dp.sv =====
// Datapath: operand registers, restoring remainder unit, binary loop and output register.
`timescale 1ns / 1ps
`default_nettype none
module ksb_dp #(
    parameter int WORD_BITS = ksb_pkg::WORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ksb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ksb_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire ksb_pkg::ksb_cmd_t             cmd,
    output ksb_pkg::ksb_sts_t                  sts
);

    localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    ksb_pkg::sym_t        k_reg;
    ksb_pkg::sym_t        res_reg;
    logic                 aneg_reg;
    logic                 bneg_reg;
    logic [2:0]           alow_reg;
    logic                 out_valid_reg;
    ksb_pkg::sym_t        out_sym_reg;

    logic [WORD_BITS-1:0] a_raw;
    logic [WORD_BITS-1:0] b_raw;
    logic [WORD_BITS-1:0] a_mag;
    logic [WORD_BITS-1:0] b_mag;
    logic [WORD_BITS:0]   div_t;
    logic [WORD_BITS:0]   div_d;
    logic [WORD_BITS:0]   a_minus_b;
    logic [WORD_BITS-1:0] b_minus_a;
    logic                 b_gt_a;
    ksb_pkg::sym_t        early_val;

    assign a_raw = s_tdata[WORD_BITS-1:0];
    assign b_raw = s_tdata[ksb_pkg::FIELD_W +: WORD_BITS];
    assign a_mag = a_raw[WORD_BITS-1] ? (~a_raw + 1'b1) : a_raw;
    assign b_mag = b_raw[WORD_BITS-1] ? (~b_raw + 1'b1) : b_raw;

    assign div_t = {rem_reg, a_reg[WORD_BITS-1]};
    assign div_d = div_t - {1'b0, b_reg};

    assign a_minus_b = {1'b0, a_reg} - {1'b0, b_reg};
    assign b_minus_a = b_reg - a_reg;
    assign b_gt_a    = a_minus_b[WORD_BITS];

    assign early_val = (b_reg == '0 && a_reg == WORD_BITS'(1)) ? ksb_pkg::SYM_POS
                                                               : ksb_pkg::SYM_ZERO;

    always_comb begin
        sts.b_zero    = (b_reg == '0);
        sts.both_even = !a_reg[0] && !b_reg[0];
        sts.b_odd     = b_reg[0];
        sts.div_last  = (cnt_reg == CNT_LAST);
        sts.a_zero    = (a_reg == '0);
        sts.out_free  = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg    <= a_mag;
            b_reg    <= b_mag;
            aneg_reg <= a_raw[WORD_BITS-1];
            bneg_reg <= b_raw[WORD_BITS-1];
            alow_reg <= a_raw[2:0];
            k_reg    <= ksb_pkg::SYM_POS;
        end
        if (cmd.set_early) begin
            res_reg <= early_val;
        end
        if (cmd.strip_b) begin
            if (b_reg[1:0] == 2'b00) begin
                b_reg <= b_reg >> 2;
            end else begin
                b_reg <= b_reg >> 1;
                k_reg <= ksb_pkg::sign_mod8(alow_reg);
            end
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            cnt_reg <= '0;
            if (aneg_reg && bneg_reg) begin
                k_reg <= ksb_pkg::sym_neg(k_reg);
            end
        end
        if (cmd.div_step) begin
            a_reg   <= a_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
            if (!div_d[WORD_BITS]) begin
                rem_reg <= div_d[WORD_BITS-1:0];
            end else begin
                rem_reg <= div_t[WORD_BITS-1:0];
            end
        end
        if (cmd.fix) begin
            if (aneg_reg && rem_reg != '0) begin
                a_reg <= b_reg - rem_reg;
            end else begin
                a_reg <= rem_reg;
            end
        end
        if (cmd.loop_step) begin
            if (a_reg[1:0] == 2'b00) begin
                a_reg <= a_reg >> 2;
            end else if (!a_reg[0]) begin
                a_reg <= a_reg >> 1;
                k_reg <= ksb_pkg::sym_mul(k_reg, ksb_pkg::sign_mod8(b_reg[2:0]));
            end else if (b_gt_a) begin
                a_reg <= b_minus_a;
                b_reg <= a_reg;
                if (a_reg[1:0] == 2'b11 && b_reg[1:0] == 2'b11) begin
                    k_reg <= ksb_pkg::sym_neg(k_reg);
                end
            end else begin
                a_reg <= a_minus_b[WORD_BITS-1:0];
            end
        end
        if (cmd.set_final) begin
            res_reg <= (|b_reg[WORD_BITS-1:1]) ? ksb_pkg::SYM_ZERO : k_reg;
        end
        if (cmd.emit) begin
            out_sym_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(ksb_pkg::M_DATA_W - ksb_pkg::SYM_W){1'b0}}, out_sym_reg};

endmodule
`default_nettype wire

// ===== rtl/kronecker_symbol_binary.sv =====
// Top level of the Kronecker symbol unit: controller plus datapath.
// Computes the Kronecker symbol (a/b) of two signed WORD_BITS-bit operands by the binary
// algorithm and returns -1, 0 or +1 as a 2-bit two's complement code. One request is in
// flight at a time: s_tready is high only while the controller is idle, and a finished
// result sits in the output register so the next request can be taken while it waits.
// After the accepting edge the controller steps through the check, strip, divide, fix,
// loop and output states: the strip state removes the trailing zeros of |b| (shift by two
// per cycle), the restoring remainder unit produces one quotient bit per cycle, and the
// binary loop does one shift or subtract per cycle until a is zero; zero b or both operands
// even go from the check state straight to the output state, which emits the result once
// the output register is free. Operand bits at and above WORD_BITS are ignored.
`timescale 1ns / 1ps
`default_nettype none
module kronecker_symbol_binary #(
    parameter int WORD_BITS = ksb_pkg::WORD_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [63:0] numerator_a, [127:64] denominator_b
    input  wire logic [ksb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] symbol, [7:2] zero
    output logic [ksb_pkg::M_DATA_W-1:0]       m_tdata
);

    ksb_pkg::ksb_cmd_t cmd;
    ksb_pkg::ksb_sts_t sts;

    ksb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ksb_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire

// ===== dv/kronecker_symbol_binary_checker.sv =====
// Checker that predicts the Kronecker symbol of each request and compares the results.
`timescale 1ns / 1ps
module kronecker_symbol_binary_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [ksb_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [ksb_pkg::M_DATA_W-1:0] m_tdata,
    output int unsigned                       fail_count,
    output int unsigned                       pending,
    output int unsigned                       n_pos,
    output int unsigned                       n_neg,
    output int unsigned                       n_zero
);
    import ksb_pkg::*;

    localparam int WB = WORD_BITS_DEF;

    sym_t expected_symbols[$];
    sym_t want;

    function automatic int mod8_sign(input logic [2:0] r);
        int s;
        case (r)
            3'd1, 3'd7: s = 1;
            3'd3, 3'd5: s = -1;
            default:    s = 0;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] to_magnitude(input logic [63:0] raw, output bit neg);
        logic [63:0] mask;
        logic [63:0] x;
        mask = (WB >= 64) ? {64{1'b1}} : ((64'd1 << WB) - 64'd1);
        x = raw & mask;
        if (x[WB-1]) begin
            x = x | ~mask;
        end
        neg = x[63];
        return neg ? (64'd0 - x) : x;
    endfunction

    function automatic sym_t kron_symbol(input logic [63:0] ra, input logic [63:0] rb);
        bit          aneg;
        bit          bneg;
        logic [63:0] amag;
        logic [63:0] bmag;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        int          k;
        amag = to_magnitude(ra, aneg);
        bmag = to_magnitude(rb, bneg);
        if (bmag == 64'd0) begin
            return (amag == 64'd1) ? SYM_POS : SYM_ZERO;
        end
        if (!amag[0] && !bmag[0]) begin
            return SYM_ZERO;
        end
        b = bmag;
        while (b[1:0] == 2'b00) begin
            b = b >> 2;
        end
        if (!b[0]) begin
            b = b >> 1;
            k = mod8_sign(ra[2:0]);
        end else begin
            k = 1;
        end
        if (aneg && bneg) begin
            k = -k;
        end
        r = amag % b;
        if (aneg && r != 64'd0) begin
            r = b - r;
        end
        a = r;
        while (a != 64'd0) begin
            while (a[1:0] == 2'b00) begin
                a = a >> 2;
            end
            if (!a[0]) begin
                a = a >> 1;
                k = k * mod8_sign(b[2:0]);
            end
            if (b > a) begin
                r = b - a;
                if (a[1:0] == 2'b11 && b[1:0] == 2'b11) begin
                    k = -k;
                end
                b = a;
                a = r;
            end else begin
                a = a - b;
            end
        end
        if (b > 64'd1 || k == 0) begin
            return SYM_ZERO;
        end
        return (k > 0) ? SYM_POS : SYM_NEG;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            fail_count = 0;
            pending    = 0;
            n_pos      = 0;
            n_neg      = 0;
            n_zero     = 0;
            expected_symbols.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_symbols.push_back(kron_symbol(s_tdata[63:0], s_tdata[127:64]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_symbols.size() == 0) begin
                    $display("%0t: result %h with no request outstanding", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (m_tdata !== {{(M_DATA_W-SYM_W){1'b0}}, want}) begin
                        $display("%0t: symbol mismatch, expected %h, actual %h", $time,
                                 {{(M_DATA_W-SYM_W){1'b0}}, want}, m_tdata);
                        fail_count++;
                    end
                    case (want)
                        SYM_POS: n_pos++;
                        SYM_NEG: n_neg++;
                        default: n_zero++;
                    endcase
                end
            end
            pending = expected_symbols.size();
        end
    end

endmodule

// ===== dv/kronecker_symbol_binary_tb.sv =====
// Testbench top for the Kronecker symbol unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module kronecker_symbol_binary_tb;
    import ksb_pkg::*;

    localparam int          RANDOM_PER_PHASE = 475;
    localparam int          HOLD_CYCLES      = 600;
    localparam int          WATCHDOG_LIMIT   = 5000;
    localparam int          DRAIN_CYCLES     = 300;
    localparam logic [63:0] MIN64            = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64            = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONES64           = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned n_pos;
    int unsigned n_neg;
    int unsigned n_zero;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned phase       = 0;
    int unsigned requests_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_left   = 0;
    bit          held        = 1'b0;
    bit          s_fire_q    = 1'b0;

    always #2 aclk = ~aclk;

    kronecker_symbol_binary DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kronecker_symbol_binary_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .n_pos      (n_pos),
        .n_neg      (n_neg),
        .n_zero     (n_zero)
    );

    always @(posedge aclk) begin
        s_fire_q <= s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold off the output once in the last phase so the block backs up
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == 3 && !held) begin
            held      <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_request(input logic [63:0] a, input logic [63:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {b, a};
        s_tvalid <= 1'b1;
        do begin
            @(negedge aclk);
        end while (!s_fire_q);
        requests_sent++;
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        int          t;
        case ($urandom_range(9))
            0: begin
                t = int'($urandom_range(40)) - 20;
                v = 64'(t);
            end
            1: begin
                case ($urandom_range(5))
                    0:       v = 64'd0;
                    1:       v = 64'd1;
                    2:       v = ONES64;
                    3:       v = MIN64;
                    4:       v = MAX64;
                    default: v = MIN64 + 64'd1;
                endcase
            end
            2: begin
                v = ({$urandom, $urandom} | 64'd1) << $urandom_range(63);
                if ($urandom_range(1)) begin
                    v = 64'd0 - v;
                end
            end
            3: begin
                t = int'($urandom);
                v = 64'(t);
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    initial begin
        tx_idle_pct = 37;
        rx_idle_pct = 69;
        phase       = 1;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_request(64'd0, 64'd0);
        send_request(64'd1, 64'd0);
        send_request(ONES64, 64'd0);
        send_request(64'd2, 64'd0);
        send_request(MIN64, 64'd0);
        send_request(MAX64, 64'd0);
        send_request(64'd2, 64'd4);
        send_request(MIN64, MIN64);
        send_request(64'd0, 64'd1);
        send_request(64'd5, MIN64);
        send_request(MAX64, MIN64);
        send_request(ONES64, MIN64);
        send_request(MIN64, 64'd3);
        send_request(MIN64, -64'sd3);
        send_request(-64'sd7, -64'sd15);
        send_request(64'd3, 64'd7);
        send_request(64'd7, 64'd3);
        send_request(MAX64, MAX64);
        send_request(MIN64, MAX64);
        send_request(ONES64, ONES64);
        send_request(64'd2, ONES64);
        send_request(-64'sd3, 64'd8);
        send_request(64'd6, 64'd9);
        send_request(64'd1, 64'd1);
        send_request(MAX64, 64'h0000_0000_FFFF_FFFB);

        repeat (RANDOM_PER_PHASE) send_request(rand_operand(), rand_operand());

        tx_idle_pct = 69;
        rx_idle_pct = 37;
        phase       = 2;
        repeat (RANDOM_PER_PHASE) send_request(rand_operand(), rand_operand());

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase       = 3;
        repeat (RANDOM_PER_PHASE) send_request(rand_operand(), rand_operand());

        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("summary: %0d requests over three flow-control phases and one long output hold",
                 requests_sent);
        $display("summary: results +1:%0d -1:%0d 0:%0d, mismatches %0d",
                 n_pos, n_neg, n_zero, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
